FILE: rtl/hsl_saturation_luminance_adjust_defines.svh
// Assertion macros for the HSL adjust block.
`ifndef HSL_SATURATION_LUMINANCE_ADJUST_DEFINES_SVH
`define HSL_SATURATION_LUMINANCE_ADJUST_DEFINES_SVH
`ifndef SYNTHESIS
`define HSLA_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("hsla check failed");
`define HSLA_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("hsla check failed");
`else
`define HSLA_ASSERT(name, prop)
`define HSLA_ASSERT_IMPLY(name, pre, post)
`endif
`endif

FILE: rtl/hsla_pkg.sv
package hsla_pkg;
   localparam int PIX_W  = 8;
   localparam int GAIN_W = 16;
   localparam int FLR_W  = 13;
   localparam int IDX_W  = 2;

   localparam logic [IDX_W-1:0] REG_SAT_GAIN = 2'd0;
   localparam logic [IDX_W-1:0] REG_LUM_GAIN = 2'd1;
   localparam logic [IDX_W-1:0] REG_LUM_FLR  = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd4096;
   localparam logic [8:0]        HUE_WRAP = 9'd360;
   // floor(2^32 / 15)
   localparam logic [31:0]       RECIP_15 = 32'h1111_1111;
   // floor(2^32 / 255)
   localparam logic [31:0]       RECIP_255 = 32'h0101_0101;
endpackage

FILE: rtl/hsla_req_if.sv
interface hsla_req_if;
   logic                         valid;
   logic                         ready;
   logic [hsla_pkg::PIX_W-1:0]   red_in;
   logic [hsla_pkg::PIX_W-1:0]   green_in;
   logic [hsla_pkg::PIX_W-1:0]   blue_in;
   modport source (output valid, output red_in, output green_in, output blue_in, input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

FILE: rtl/hsla_rsp_if.sv
interface hsla_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hsla_pkg::PIX_W-1:0]   red_out;
   logic [hsla_pkg::PIX_W-1:0]   green_out;
   logic [hsla_pkg::PIX_W-1:0]   blue_out;
   modport source (output valid, output red_out, output green_out, output blue_out,
                   input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   output ready);
endinterface

FILE: rtl/hsla_csr_if.sv
interface hsla_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hsla_pkg::IDX_W-1:0]    index;
   logic [hsla_pkg::GAIN_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/hsl_saturation_luminance_adjust.sv
// HSL saturation / luminance adjust, one 8-bit RGB pixel per item.
// req_if carries the input pixel, rsp_if the adjusted pixel; both are
// valid/ready channels and an item moves when valid and ready are high.
// csr_if writes the registers: index 0 saturation gain (Q4.12), index 1
// luminance gain (Q4.12), index 2 luminance floor (Q1.12); other indexes
// are dropped. csr_if.ready is always high. Write registers only while
// the pipeline is empty.
// Throughput: one item per clock unless rsp_if.ready stalls the pipeline.
// The pipeline depth is set by the radix-2 divider, one saturation quotient
// bit per stage for Q1.FRAC_BITS (luminance divides by a constant through a
// reciprocal multiply in the first two of those stages), followed by gain,
// clamp and HSL-to-RGB stages.
// Reset clears all stage valid bits and loads gains of 1.0 and a floor of 0;
// with those values pixels pass through unchanged.
// When rsp_if.ready is low while a result is shown, the whole pipeline holds
// and req_if.ready drops; nothing is lost or repeated.
`include "hsl_saturation_luminance_adjust_defines.svh"
module hsl_saturation_luminance_adjust #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   hsla_req_if.sink    req_if,
   hsla_rsp_if.source  rsp_if,
   hsla_csr_if.sink    csr_if
);
   import hsla_pkg::*;

   localparam int F      = FRAC_BITS;
   localparam int QW     = F + 1;
   localparam int DIV_N  = F + 1;
   localparam int HUE_W  = 7;
   // width of sum << (F - 1)
   localparam int LN_W   = F + 8;
   localparam logic [QW-1:0] ONE_F  = QW'(1) << F;
   localparam logic [QW-1:0] HALF_F = QW'(1) << (F - 1);

   typedef struct packed {
      logic          valid;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
      logic          grey;
      logic [8:0]    den;
      logic [7:0]    diff;
      logic [9:0]    srem;
      logic [QW-1:0] squo;
      logic [9:0]    lrem;
      logic [QW-1:0] lquo;
      logic [14:0]   hrem;
      logic [6:0]    hquo;
      logic [8:0]    hbase;
   } div_type;

   function automatic logic [5:0] chan_weight(input logic [8:0] t);
      logic [5:0] k;
      if (t < 9'd60)       k = t[5:0];
      else if (t < 9'd180) k = 6'd60;
      else if (t < 9'd240) k = 6'(9'd240 - t);
      else                 k = 6'd0;
      return k;
   endfunction

   // configuration
   logic [GAIN_W-1:0] sg_ff, lg_ff;
   logic [FLR_W-1:0]  fl_ff;
   logic              bypass;

   assign csr_if.ready = 1'b1;
   assign bypass = (sg_ff == GAIN_ONE) && (lg_ff == GAIN_ONE) && (fl_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         sg_ff <= GAIN_ONE;
         lg_ff <= GAIN_ONE;
         fl_ff <= '0;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            REG_SAT_GAIN: sg_ff <= csr_if.data;
            REG_LUM_GAIN: lg_ff <= csr_if.data;
            REG_LUM_FLR:  fl_ff <= csr_if.data[FLR_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;

   // input register
   logic       p0_vld_ff;
   logic [7:0] p0_r_ff, p0_g_ff, p0_b_ff;

   always_ff @(posedge clock) begin
      if (reset)    p0_vld_ff <= 1'b0;
      else if (adv) p0_vld_ff <= req_if.valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         p0_r_ff <= req_if.red_in;
         p0_g_ff <= req_if.green_in;
         p0_b_ff <= req_if.blue_in;
      end
   end

   // RGB to max/min, divider setup
   div_type div_in [0:DIV_N];
   div_type div_ff [0:DIV_N];

   always_comb begin
      logic [7:0]        mx, mn, df;
      logic [8:0]        sm;
      logic signed [9:0] x;
      logic signed [9:0] dpx;
      mx = (p0_r_ff > p0_g_ff) ? p0_r_ff : p0_g_ff;
      if (p0_b_ff > mx) mx = p0_b_ff;
      mn = (p0_r_ff < p0_g_ff) ? p0_r_ff : p0_g_ff;
      if (p0_b_ff < mn) mn = p0_b_ff;
      df = mx - mn;
      sm = {1'b0, mx} + {1'b0, mn};
      div_in[0]        = '0;
      div_in[0].valid  = p0_vld_ff;
      div_in[0].red    = p0_r_ff;
      div_in[0].green  = p0_g_ff;
      div_in[0].blue   = p0_b_ff;
      div_in[0].grey   = (df == '0);
      div_in[0].diff   = df;
      div_in[0].den    = (sm < 9'd255) ? sm : 9'(10'd510 - {1'b0, sm});
      div_in[0].srem   = {2'b00, df};
      div_in[0].lrem   = {1'b0, sm};
      if (mx == p0_r_ff) begin
         div_in[0].hbase = 9'd300;
         x = $signed({2'b00, p0_g_ff}) - $signed({2'b00, p0_b_ff});
      end else if (mx == p0_g_ff) begin
         div_in[0].hbase = 9'd60;
         x = $signed({2'b00, p0_b_ff}) - $signed({2'b00, p0_r_ff});
      end else begin
         div_in[0].hbase = 9'd180;
         x = $signed({2'b00, p0_r_ff}) - $signed({2'b00, p0_g_ff});
      end
      dpx = $signed({2'b00, df}) + x;
      div_in[0].hrem = 15'(dpx[8:0]) * 15'd60;
   end

   // restoring divider, one quotient bit per stage
   for (genvar j = 0; j < DIV_N; j++) begin : g_div
      localparam int HS = (j < HUE_W) ? (HUE_W - 1 - j) : 0;
      always_comb begin
         logic [9:0]       s_r;
         logic [14:0]      h_d;
         logic [LN_W-1:0]  ln, lr;
         logic [LN_W+31:0] le;
         div_in[j+1] = div_ff[j];
         s_r = (j == 0) ? div_ff[j].srem : {div_ff[j].srem[8:0], 1'b0};
         h_d = 15'(div_ff[j].diff) << HS;
         // luminance: sum * 2^(F-1) / 255 by reciprocal, then one correction step
         ln = LN_W'(div_ff[j].lrem) << (F - 1);
         le = '0;
         lr = '0;
         if (j == 0) begin
            le = (LN_W+32)'(ln) * (LN_W+32)'(RECIP_255);
            div_in[j+1].lquo = le[QW+31:32];
         end else if (j == 1) begin
            lr = ln - ((LN_W'(div_ff[j].lquo) << 8) - LN_W'(div_ff[j].lquo));
            if (lr >= LN_W'(255)) div_in[j+1].lquo = div_ff[j].lquo + QW'(1);
         end
         if (s_r >= {1'b0, div_ff[j].den}) begin
            div_in[j+1].squo[F-j] = 1'b1;
            s_r = s_r - {1'b0, div_ff[j].den};
         end
         div_in[j+1].srem = s_r;
         if ((j < HUE_W) && (div_ff[j].hrem >= h_d)) begin
            div_in[j+1].hquo[HS] = 1'b1;
            div_in[j+1].hrem     = div_ff[j].hrem - h_d;
         end
      end
   end

   for (genvar j = 0; j <= DIV_N; j++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset)    div_ff[j].valid <= 1'b0;
         else if (adv) div_ff[j] <= div_in[j];
      end
   end

   // stage A: gains
   logic          a_vld_ff;
   logic [23:0]   a_rgb_ff;
   logic [QW+3:0] a_sat_ff, a_lum_ff, a_sat_in, a_lum_in;
   logic [8:0]    a_hue_ff, a_hue_in;

   always_comb begin
      logic [QW-1:0]    sat_raw;
      logic [QW+15:0]   sp, lp;
      logic [8:0]       hs;
      sat_raw  = div_ff[DIV_N].grey ? '0 : div_ff[DIV_N].squo;
      sp       = (QW+16)'(sat_raw) * (QW+16)'(sg_ff);
      lp       = (QW+16)'(div_ff[DIV_N].lquo) * (QW+16)'(lg_ff);
      a_sat_in = sp[QW+15:12];
      a_lum_in = lp[QW+15:12];
      hs       = div_ff[DIV_N].hbase + {2'b00, div_ff[DIV_N].hquo};
      a_hue_in = (hs >= HUE_WRAP) ? hs - HUE_WRAP : hs;
   end

   always_ff @(posedge clock) begin
      if (reset)    a_vld_ff <= 1'b0;
      else if (adv) a_vld_ff <= div_ff[DIV_N].valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         a_rgb_ff <= {div_ff[DIV_N].red, div_ff[DIV_N].green, div_ff[DIV_N].blue};
         a_sat_ff <= a_sat_in;
         a_lum_ff <= a_lum_in;
         a_hue_ff <= a_hue_in;
      end
   end

   // stage B: caps and floor
   logic          b_vld_ff;
   logic [23:0]   b_rgb_ff;
   logic [QW-1:0] b_sat_ff, b_lum_ff, b_sat_in, b_lum_in;
   logic [8:0]    b_hue_ff;

   always_comb begin
      logic [QW-1:0] fl;
      logic [QW+3:0] lum;
      fl       = QW'(fl_ff) << (F - 12);
      b_sat_in = (a_sat_ff > (QW+4)'(ONE_F)) ? ONE_F : a_sat_ff[QW-1:0];
      lum      = a_lum_ff;
      if (a_lum_ff < (QW+4)'(fl)) begin
         b_sat_in = '0;
         lum      = (QW+4)'(fl);
      end
      b_lum_in = (lum > (QW+4)'(ONE_F)) ? ONE_F : lum[QW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset)    b_vld_ff <= 1'b0;
      else if (adv) b_vld_ff <= a_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         b_rgb_ff <= a_rgb_ff;
         b_sat_ff <= b_sat_in;
         b_lum_ff <= b_lum_in;
         b_hue_ff <= a_hue_ff;
      end
   end

   // stage C: lum * sat
   logic          c_vld_ff;
   logic [23:0]   c_rgb_ff;
   logic [QW-1:0] c_sat_ff, c_lum_ff, c_ls_ff;
   logic [2*QW-1:0] c_prod;
   logic [8:0]    c_hue_ff;

   assign c_prod = (2*QW)'(b_lum_ff) * (2*QW)'(b_sat_ff);

   always_ff @(posedge clock) begin
      if (reset)    c_vld_ff <= 1'b0;
      else if (adv) c_vld_ff <= b_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         c_rgb_ff <= b_rgb_ff;
         c_sat_ff <= b_sat_ff;
         c_lum_ff <= b_lum_ff;
         c_ls_ff  <= c_prod[F+QW-1:F];
         c_hue_ff <= b_hue_ff;
      end
   end

   // stage D: p, q and channel weights
   logic          d_vld_ff;
   logic [23:0]   d_rgb_ff;
   logic [QW-1:0] d_p_ff, d_d_ff, d_p_in, d_d_in;
   logic [5:0]    d_k_ff [3];
   logic [5:0]    d_k_in [3];

   always_comb begin
      logic [QW:0]          qt;
      logic [QW-1:0]        qc;
      logic signed [QW+1:0] pt;
      logic [8:0]           t [3];
      if (c_lum_ff < HALF_F) qt = {1'b0, c_lum_ff} + {1'b0, c_ls_ff};
      else qt = {1'b0, c_lum_ff} + {1'b0, c_sat_ff} - {1'b0, c_ls_ff};
      qc = (qt > {1'b0, ONE_F}) ? ONE_F : qt[QW-1:0];
      pt = $signed({1'b0, c_lum_ff, 1'b0}) - $signed({2'b00, qc});
      if (pt < 0)                            d_p_in = '0;
      else if (pt > $signed({2'b00, ONE_F})) d_p_in = ONE_F;
      else                                   d_p_in = pt[QW-1:0];
      d_d_in = qc - d_p_in;
      if (c_sat_ff == '0) begin
         // grey: every channel takes the luminance
         d_p_in = c_lum_ff;
         d_d_in = '0;
      end
      t[0] = (c_hue_ff + 9'd120 > HUE_WRAP) ? c_hue_ff - 9'd240 : c_hue_ff + 9'd120;
      t[1] = c_hue_ff;
      t[2] = (c_hue_ff < 9'd120) ? c_hue_ff + 9'd240 : c_hue_ff - 9'd120;
      for (int i = 0; i < 3; i++) d_k_in[i] = chan_weight(t[i]);
   end

   always_ff @(posedge clock) begin
      if (reset)    d_vld_ff <= 1'b0;
      else if (adv) d_vld_ff <= c_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         d_rgb_ff <= c_rgb_ff;
         d_p_ff   <= d_p_in;
         d_d_ff   <= d_d_in;
         for (int i = 0; i < 3; i++) d_k_ff[i] <= d_k_in[i];
      end
   end

   // stage E: d * weight, pre-shift for the divide by 60
   logic          e_vld_ff;
   logic [23:0]   e_rgb_ff;
   logic [QW-1:0] e_p_ff;
   logic [QW+3:0] e_y_ff [3];
   logic [QW+5:0] e_x [3];

   always_comb begin
      for (int i = 0; i < 3; i++) e_x[i] = (QW+6)'(d_d_ff) * (QW+6)'(d_k_ff[i]);
   end

   always_ff @(posedge clock) begin
      if (reset)    e_vld_ff <= 1'b0;
      else if (adv) e_vld_ff <= d_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         e_rgb_ff <= d_rgb_ff;
         e_p_ff   <= d_p_ff;
         for (int i = 0; i < 3; i++) e_y_ff[i] <= e_x[i][QW+5:2];
      end
   end

   // stage F: reciprocal multiply for y / 15
   logic          f_vld_ff;
   logic [23:0]   f_rgb_ff;
   logic [QW-1:0] f_p_ff;
   logic [QW+3:0] f_y_ff [3];
   logic [QW-1:0] f_q_ff [3];
   logic [QW+35:0] f_e [3];

   always_comb begin
      for (int i = 0; i < 3; i++) f_e[i] = (QW+36)'(e_y_ff[i]) * (QW+36)'(RECIP_15);
   end

   always_ff @(posedge clock) begin
      if (reset)    f_vld_ff <= 1'b0;
      else if (adv) f_vld_ff <= e_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         f_rgb_ff <= e_rgb_ff;
         f_p_ff   <= e_p_ff;
         for (int i = 0; i < 3; i++) begin
            f_y_ff[i] <= e_y_ff[i];
            f_q_ff[i] <= f_e[i][QW+31:32];
         end
      end
   end

   // stage G: correct the quotient, add p
   logic          g_vld_ff;
   logic [23:0]   g_rgb_ff;
   logic [QW-1:0] g_v_ff [3];
   logic [QW-1:0] g_v_in [3];

   always_comb begin
      logic [QW+3:0] m15, rm;
      logic [QW-1:0] qq;
      logic [QW:0]   sm;
      for (int i = 0; i < 3; i++) begin
         m15 = ((QW+4)'(f_q_ff[i]) << 4) - (QW+4)'(f_q_ff[i]);
         rm  = f_y_ff[i] - m15;
         qq  = (rm >= (QW+4)'(15)) ? f_q_ff[i] + QW'(1) : f_q_ff[i];
         sm  = {1'b0, f_p_ff} + {1'b0, qq};
         g_v_in[i] = sm[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    g_vld_ff <= 1'b0;
      else if (adv) g_vld_ff <= f_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         g_rgb_ff <= f_rgb_ff;
         for (int i = 0; i < 3; i++) g_v_ff[i] <= g_v_in[i];
      end
   end

   // stage H: to bytes, output register
   logic       h_vld_ff;
   logic [7:0] h_pix_ff [3];
   logic [7:0] h_pix_in [3];

   always_comb begin
      logic [QW+7:0] s255;
      for (int i = 0; i < 3; i++) begin
         s255 = ((QW+8)'(g_v_ff[i]) << 8) - (QW+8)'(g_v_ff[i]);
         h_pix_in[i] = bypass ? g_rgb_ff[23-8*i -: 8] : s255[F+7:F];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)    h_vld_ff <= 1'b0;
      else if (adv) h_vld_ff <= g_vld_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) h_pix_ff[i] <= h_pix_in[i];
      end
   end

   assign rsp_if.valid     = h_vld_ff;
   assign rsp_if.red_out   = h_pix_ff[0];
   assign rsp_if.green_out = h_pix_ff[1];
   assign rsp_if.blue_out  = h_pix_ff[2];

   `HSLA_ASSERT_IMPLY(a_stall_blocks_input, rsp_if.valid && !rsp_if.ready, !req_if.ready)
   `HSLA_ASSERT_IMPLY(a_sat_in_range, div_ff[DIV_N].valid && !div_ff[DIV_N].grey, div_ff[DIV_N].squo <= ONE_F)
   `HSLA_ASSERT_IMPLY(a_lum_in_range, div_ff[DIV_N].valid, div_ff[DIV_N].lquo <= ONE_F)
   `HSLA_ASSERT_IMPLY(a_hue_in_range, a_vld_ff, a_hue_ff < HUE_WRAP)

endmodule

FILE: sim/tb_ifs.sv
`timescale 1ns / 1ps
package tb_pix_pkg;
   typedef struct packed {
      logic [hsla_pkg::PIX_W-1:0] red;
      logic [hsla_pkg::PIX_W-1:0] green;
      logic [hsla_pkg::PIX_W-1:0] blue;
   } pixel_type;
endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import hsla_pkg::*;
   import tb_pix_pkg::*;

   localparam int FRAC = 16;
   localparam longint ONE = longint'(1) << FRAC;
   localparam longint HALF = longint'(1) << (FRAC - 1);
   localparam int LATENCY = FRAC + 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

   logic clock;
   logic reset;

   hsla_req_if req_if ();
   hsla_rsp_if rsp_if ();
   hsla_csr_if csr_if ();

   hsl_saturation_luminance_adjust #(.FRAC_BITS(FRAC)) i_dut (
      .clock(clock), .reset(reset),
      .req_if(req_if), .rsp_if(rsp_if), .csr_if(csr_if)
   );

   logic [GAIN_W-1:0] sat_gain;
   logic [GAIN_W-1:0] lum_gain;
   logic [FLR_W-1:0]  lum_floor;

   pixel_type pending_pixels[$];
   pixel_type expected_pixels[$];
   bit     hold_sender;
   int     mismatches;
   int     cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] frac_to_byte(longint v);
      if (v < 0) v = 0;
      if (v > ONE) v = ONE;
      v = (v * 255) >>> FRAC;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   function automatic longint hue_channel(longint t, longint p, longint q);
      longint d;
      d = q - p;
      if (d < 0) d = 0;
      if (t < 60) return p + (d * t) / 60;
      if (t < 180) return q;
      if (t < 240) return p + (d * (240 - t)) / 60;
      return p;
   endfunction

   function automatic pixel_type adjust_pixel(pixel_type px);
      pixel_type res;
      longint r, g, b, mx, mn, diff, sum, lum, sat, hue, fl, p, q;
      longint t[3];
      logic [7:0] o[3];
      r = px.red;
      g = px.green;
      b = px.blue;
      if (sat_gain == GAIN_ONE && lum_gain == GAIN_ONE && lum_floor == 0) return px;
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      diff = mx - mn;
      sum = mx + mn;
      lum = (sum * ONE) / 510;
      sat = 0;
      hue = 0;
      if (diff != 0) begin
         if (sum < 255) sat = (diff * ONE) / sum;
         else sat = (diff * ONE) / (510 - sum);
         if (mx == r) begin
            hue = (360 * diff + 60 * (g - b)) / diff;
            if (hue > 359) hue -= 360;
         end else if (mx == g) begin
            hue = (120 * diff + 60 * (b - r)) / diff;
         end else begin
            hue = (240 * diff + 60 * (r - g)) / diff;
         end
      end
      sat = (sat * longint'(sat_gain)) >>> 12;
      if (sat > ONE) sat = ONE;
      lum = (lum * longint'(lum_gain)) >>> 12;
      fl = longint'(lum_floor) << (FRAC - 12);
      if (lum < fl) begin
         sat = 0;
         lum = fl;
      end
      if (lum > ONE) lum = ONE;
      if (sat == 0) begin
         res.red = frac_to_byte(lum);
         res.green = res.red;
         res.blue = res.red;
         return res;
      end
      if (lum < HALF) q = lum + ((lum * sat) >>> FRAC);
      else q = lum + sat - ((lum * sat) >>> FRAC);
      if (q < 0) q = 0;
      if (q > ONE) q = ONE;
      p = 2 * lum - q;
      if (p < 0) p = 0;
      if (p > ONE) p = ONE;
      t[0] = hue + 120;
      t[1] = hue;
      t[2] = hue - 120;
      for (int i = 0; i < 3; i++) begin
         if (t[i] < 0) t[i] += 360;
         if (t[i] > 360) t[i] -= 360;
         o[i] = frac_to_byte(hue_channel(t[i], p, q));
      end
      res.red = o[0];
      res.green = o[1];
      res.blue = o[2];
      return res;
   endfunction

   // driver: bursts with random gaps
   int burst_left;
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_pixels.push_back(adjust_pixel({req_if.red_in, req_if.green_in,
                                                    req_if.blue_in}));
            void'(pending_pixels.pop_front());
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (hold_sender || pending_pixels.size() == 0) begin
               req_if.valid <= 1'b0;
            end else begin
               pixel_type nx;
               nx = pending_pixels[0];
               req_if.valid <= 1'b1;
               req_if.red_in <= nx.red;
               req_if.green_in <= nx.green;
               req_if.blue_in <= nx.blue;
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(40, 1);
                  gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // monitor with its own stall pattern
   logic [7:0] stall_lfsr;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_lfsr <= 8'h5a;
         mismatches <= 0;
      end else begin
         stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4]
                        ^ stall_lfsr[3]};
         rsp_if.ready <= (cycles % 3000 < 1500) ? 1'b1 : (stall_lfsr[2:0] != 3'd0);
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_pixels.size() == 0) begin
               if (mismatches < 10) $display("unexpected pixel %h %h %h",
                  rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out);
               mismatches <= mismatches + 1;
            end else begin
               pixel_type want;
               want = expected_pixels.pop_front();
               if (want.red !== rsp_if.red_out || want.green !== rsp_if.green_out ||
                   want.blue !== rsp_if.blue_out) begin
                  if (mismatches < 10)
                     $display("pixel mismatch: expected %h %h %h got %h %h %h",
                        want.red, want.green, want.blue,
                        rsp_if.red_out, rsp_if.green_out, rsp_if.blue_out);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) cycles <= 0;
      else cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
      csr_if.index <= idx;
      csr_if.data <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         REG_SAT_GAIN: sat_gain = value;
         REG_LUM_GAIN: lum_gain = value;
         REG_LUM_FLR: lum_floor = value[FLR_W-1:0];
         default: ;
      endcase
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      wait (pending_pixels.size() == 0);
      @(posedge clock);
      while (req_if.valid || expected_pixels.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic add_pixel(int r, int g, int b);
      pixel_type px;
      px.red = 8'(r);
      px.green = 8'(g);
      px.blue = 8'(b);
      pending_pixels.push_back(px);
   endtask

   task automatic add_directed();
      add_pixel(0, 0, 0);
      add_pixel(255, 255, 255);
      add_pixel(128, 128, 128);
      add_pixel(255, 0, 0);
      add_pixel(0, 255, 0);
      add_pixel(0, 0, 255);
      add_pixel(255, 0, 1);
      add_pixel(255, 255, 0);
      add_pixel(0, 255, 255);
      add_pixel(255, 0, 255);
      add_pixel(200, 30, 90);
      add_pixel(10, 20, 250);
      add_pixel(170, 85, 85);
      add_pixel(1, 0, 0);
      add_pixel(254, 255, 254);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(7, 0) == 0) begin
            int v;
            v = $urandom_range(255, 0);
            add_pixel(v, v, v);
         end else begin
            add_pixel($urandom_range(255, 0), $urandom_range(255, 0),
                      $urandom_range(255, 0));
         end
      end
   endtask

   initial begin
      logic [GAIN_W-1:0] settings[8][3];
      settings = '{
         '{16'd4096, 16'd4096, 16'd0},
         '{16'd8192, 16'd4096, 16'd0},
         '{16'd0, 16'd65535, 16'd0},
         '{16'd65535, 16'd2048, 16'd1024},
         '{16'd2048, 16'd0, 16'd4096},
         '{16'd5000, 16'd6000, 16'd8191},
         '{16'd4096, 16'd4096, 16'd1},
         '{16'd3000, 16'd4500, 16'd300}
      };
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.red_in = '0;
      req_if.green_in = '0;
      req_if.blue_in = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      hold_sender = 1'b0;
      sat_gain = GAIN_ONE;
      lum_gain = GAIN_ONE;
      lum_floor = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // unknown index must be dropped
      write_reg(REG_UNUSED, 16'hffff);
      for (int s = 0; s < 8; s++) begin
         write_reg(REG_SAT_GAIN, settings[s][0]);
         write_reg(REG_LUM_GAIN, settings[s][1]);
         write_reg(REG_LUM_FLR, settings[s][2]);
         add_directed();
         add_random(60);
         // hold the sender once until the pipeline empties
         wait (pending_pixels.size() < 30);
         hold_sender = 1'b1;
         while (expected_pixels.size() != 0 || req_if.valid) @(posedge clock);
         hold_sender = 1'b0;
         add_random(50);
         drain();
      end
      for (int s = 0; s < 4; s++) begin
         write_reg(REG_SAT_GAIN, 16'($urandom_range(65535, 0)));
         write_reg(REG_LUM_GAIN, 16'($urandom_range(12000, 0)));
         write_reg(REG_LUM_FLR, 16'($urandom_range(8191, 0)) &
                                (($urandom_range(1, 0) != 0) ? 16'h1fff : 16'h03ff));
         add_random(40);
         drain();
      end
      if (mismatches == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+rtl
rtl/hsla_pkg.sv
rtl/hsla_req_if.sv
rtl/hsla_rsp_if.sv
rtl/hsla_csr_if.sv
rtl/hsl_saturation_luminance_adjust.sv
sim/tb_ifs.sv
sim/tb_top.sv
